// ===== rtl/core/idsa_pkg.sv =====
// ----------------------------------------------------------------------------
// idsa_pkg
// Shared types and codes of the identifier stack allocator.
// ----------------------------------------------------------------------------
package idsa_pkg;

    localparam int ID_W    = 16;
    localparam int CNT_W   = 13;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 17;   // holds counts up to 65536

    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_INUSE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OUT_RANGE = 2'd3;

    localparam logic CFG_IDX_BASE  = 1'b0;
    localparam logic CFG_IDX_COUNT = 1'b1;

    // Result of checking one identifier against the current range.
    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] offset;
    } id_chk_t;

endpackage

// ===== rtl/core/id_stack_allocator_top.sv =====
// ----------------------------------------------------------------------------
// id_stack_allocator_top
// Identifier allocator: LIFO stack of free identifiers plus in-use bits.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                      Contents
//  -------  ---  -------------------------  -----------------------------------
//  s_       in   s_tvalid/s_tready/s_tdata  tdata: release_id; tuser: command
//  m_       out  m_tvalid/m_tready/m_tdata  tdata: granted_id; tuser: status
//  cfg_     in   cfg_wr_en/addr/wr_data     0 id_base, 1 id_count
//
//  Allocate, release and the unused command each do a memory read, then a
//  modify and write back; a new request is taken only after the write-back.
//  Init sweeps the whole in-use store, one entry a cycle.
//  After reset a clearing pass over the in-use store runs with s_tready low.
//  A result waits in the output register; a stalled m_ side holds the
//  following request in its write-back cycle until the register frees up.
//
module id_stack_allocator_top #(
    parameter int NUM_IDS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] release_id
    input  logic [1:0]  s_tuser,     // [1:0]  command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] granted_id
    output logic [1:0]  m_tuser,     // [1:0]  status

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import idsa_pkg::*;

    localparam int SLOT_W  = $clog2(NUM_IDS);
    localparam int DEPTH_W = $clog2(NUM_IDS + 1);
    localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(NUM_IDS);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(NUM_IDS - 1);

    localparam logic [2:0] FSM_CLEAR = 3'd0;
    localparam logic [2:0] FSM_IDLE  = 3'd1;
    localparam logic [2:0] FSM_EXEC  = 3'd2;
    localparam logic [2:0] FSM_FILL  = 3'd3;
    localparam logic [2:0] FSM_DONE  = 3'd4;

    // Configuration.
    logic [ID_W-1:0]  base_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= ID_W'(300);
            count_reg <= CNT_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IDX_BASE:  base_reg  <= cfg_wr_data;
                CFG_IDX_COUNT: count_reg <= cfg_wr_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Control state.
    logic [2:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic [LIMIT_W-1:0] fill_n_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    rel_reg;
    logic               rel_ok_reg;
    logic [SLOT_W-1:0]  rel_slot_reg;

    logic               m_tvalid_reg;
    logic [ID_W-1:0]    m_tdata_reg;
    logic [STAT_W-1:0]  m_tuser_reg;

    // Range checks: one on the incoming request, one on the popped entry.
    logic [LIMIT_W-1:0] eff_count;
    logic [LIMIT_W-1:0] eff_count_g;
    id_chk_t            rel_chk;
    id_chk_t            grant_chk;

    // Memory ports.
    logic               stk_we, stk_re;
    logic [SLOT_W-1:0]  stk_waddr, stk_raddr;
    logic [ID_W-1:0]    stk_wdata, stk_rdata;
    logic               bit_we, bit_re;
    logic [SLOT_W-1:0]  bit_waddr, bit_raddr;
    logic               bit_wdata, bit_rdata;

    logic               s_fire, out_free, exec_fire, done_fire;
    logic [ID_W-1:0]    res_id;
    logic [STAT_W-1:0]  res_stat;

    idsa_range #(.NUM_IDS(NUM_IDS)) u_rel_range (
        .id_base   (base_reg),
        .id_count  (count_reg),
        .ident     (s_tdata),
        .eff_count (eff_count),
        .chk       (rel_chk)
    );

    idsa_range #(.NUM_IDS(NUM_IDS)) u_grant_range (
        .id_base   (base_reg),
        .id_count  (count_reg),
        .ident     (stk_rdata),
        .eff_count (eff_count_g),
        .chk       (grant_chk)
    );

    idsa_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS), .ADDR_W(SLOT_W)) u_free_stack (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    idsa_ram #(.WIDTH(1), .DEPTH(NUM_IDS), .ADDR_W(SLOT_W)) u_in_use (
        .aclk    (aclk),
        .wr_en   (bit_we),
        .wr_addr (bit_waddr),
        .wr_data (bit_wdata),
        .rd_en   (bit_re),
        .rd_addr (bit_raddr),
        .rd_data (bit_rdata)
    );

    assign s_tready  = (state_reg == FSM_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == FSM_EXEC) && out_free;
    assign done_fire = (state_reg == FSM_DONE) && out_free;

    // Read both stores on acceptance: top of stack and the released slot.
    assign stk_re    = s_fire;
    assign stk_raddr = SLOT_W'(depth_reg - DEPTH_W'(1));
    assign bit_re    = s_fire;
    assign bit_raddr = rel_chk.offset[SLOT_W-1:0];

    // Result of the request in write-back.
    always_comb begin
        res_id   = '0;
        res_stat = STAT_OK;
        case (cmd_reg)
            CMD_ALLOC: begin
                if (depth_reg == '0) begin
                    res_stat = STAT_EXHAUSTED;
                end else begin
                    res_id = stk_rdata;
                end
            end
            CMD_RELEASE: begin
                if (!rel_ok_reg) begin
                    res_stat = STAT_OUT_RANGE;
                end else if (!bit_rdata) begin
                    res_stat = STAT_NOT_INUSE;
                end
            end
            default: ;
        endcase
    end

    // Write-back, fill sweep and clearing pass.
    always_comb begin
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[SLOT_W-1:0];
        stk_wdata  = rel_reg;
        bit_we     = 1'b0;
        bit_waddr  = cnt_reg;
        bit_wdata  = 1'b0;
        state_next = state_reg;
        depth_next = depth_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FSM_CLEAR: begin
                bit_we = 1'b1;
                cnt_next = cnt_reg + SLOT_W'(1);
                if (cnt_reg == LAST_SLOT) begin
                    cnt_next   = '0;
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == CMD_INIT) ? FSM_FILL : FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (exec_fire) begin
                    state_next = FSM_IDLE;
                    if (cmd_reg == CMD_ALLOC && depth_reg != '0) begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        bit_we     = grant_chk.ok;
                        bit_waddr  = grant_chk.offset[SLOT_W-1:0];
                        bit_wdata  = 1'b1;
                    end
                    if (cmd_reg == CMD_RELEASE && rel_ok_reg && bit_rdata) begin
                        bit_we    = 1'b1;
                        bit_waddr = rel_slot_reg;
                        bit_wdata = 1'b0;
                        // Drop the push on a full stack.
                        if (depth_reg < FULL_DEPTH) begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                end
            end
            FSM_FILL: begin
                bit_we    = 1'b1;
                stk_we    = (LIMIT_W'(cnt_reg) < fill_n_reg);
                stk_waddr = cnt_reg;
                stk_wdata = base_reg + ID_W'(cnt_reg);
                cnt_next  = cnt_reg + SLOT_W'(1);
                if (cnt_reg == LAST_SLOT) begin
                    cnt_next   = '0;
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (done_fire) begin
                    depth_next = fill_n_reg[DEPTH_W-1:0];
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_CLEAR;
            depth_reg    <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            cnt_reg   <= cnt_next;
            if (exec_fire || done_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload: no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg      <= s_tuser;
            rel_reg      <= s_tdata;
            rel_ok_reg   <= rel_chk.ok;
            rel_slot_reg <= rel_chk.offset[SLOT_W-1:0];
            fill_n_reg   <= eff_count;
        end
        if (exec_fire) begin
            m_tdata_reg <= res_id;
            m_tuser_reg <= res_stat;
        end else if (done_fire) begin
            m_tdata_reg <= '0;
            m_tuser_reg <= STAT_OK;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Both range instances see the same registers.
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        eff_count == eff_count_g)
        else $error("range units disagree on effective count");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= FULL_DEPTH)
        else $error("stack depth beyond store depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_alloc_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && cmd_reg == CMD_ALLOC && res_stat == STAT_OK
        |=> depth_reg == $past(depth_reg) - DEPTH_W'(1))
        else $error("allocate did not pop the stack");

    a_fill_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done_fire |=> m_tvalid && m_tuser == STAT_OK && depth_reg == $past(fill_n_reg[DEPTH_W-1:0]))
        else $error("init result or depth wrong");

endmodule

// ===== rtl/core/idsa_ram.sv =====
// ----------------------------------------------------------------------------
// idsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module idsa_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/idsa_range.sv =====
// ----------------------------------------------------------------------------
// idsa_range
// Effective identifier count and range check of one identifier.
// ----------------------------------------------------------------------------
module idsa_range #(
    parameter int NUM_IDS = 4096
) (
    input  logic [idsa_pkg::ID_W-1:0]    id_base,
    input  logic [idsa_pkg::CNT_W-1:0]   id_count,
    input  logic [idsa_pkg::ID_W-1:0]    ident,
    output logic [idsa_pkg::LIMIT_W-1:0] eff_count,
    output idsa_pkg::id_chk_t            chk
);
    import idsa_pkg::*;

    localparam logic [LIMIT_W-1:0] NUM_IDS_L = LIMIT_W'(NUM_IDS);

    logic [LIMIT_W-1:0] room;
    logic [LIMIT_W-1:0] cnt_ext;
    logic [LIMIT_W-1:0] n_a;
    logic [ID_W-1:0]    offset;

    // Clamp to store depth and to the top of the identifier space.
    always_comb begin
        room    = LIMIT_W'(65536) - {1'b0, id_base};
        cnt_ext = LIMIT_W'(id_count);
        n_a     = (cnt_ext > NUM_IDS_L) ? NUM_IDS_L : cnt_ext;
        eff_count = (n_a > room) ? room : n_a;
    end

    assign offset     = ident - id_base;
    assign chk.offset = offset;
    assign chk.ok     = (ident >= id_base) && ({1'b0, offset} < eff_count);

endmodule
